// ----- rtl/rgcd_pkg.sv -----
// Shared types for the running GCD resolution block.
`timescale 1ns / 1ps

package rgcd_pkg;

    // Width of the resolution result field.
    localparam int unsigned RES_W = 31;

    // Sequencer states of the top level.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_EMIT
    } t_state;

    // Request from the sequencer to the GCD unit.
    typedef struct packed {
        logic start;
    } t_gcd_req;

    // Status from the GCD unit back to the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } t_gcd_rsp;

endpackage

// ----- rtl/rgcd_core.sv -----
// Iterative binary GCD unit: one shift or subtract-and-shift step per cycle.
`timescale 1ns / 1ps

module rgcd_core #(
    parameter int unsigned DW = 31
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rgcd_pkg::t_gcd_req i_req,
    input  logic [DW-1:0]     i_a,
    input  logic [DW-1:0]     i_b,
    output rgcd_pkg::t_gcd_rsp o_rsp,
    output logic [DW-1:0]     o_gcd
);
    import rgcd_pkg::*;

    localparam int unsigned K_W = $clog2(DW + 1);

    logic [DW-1:0]  r_a, n_a;
    logic [DW-1:0]  r_b, n_b;
    logic [K_W-1:0] r_k, n_k;
    logic           r_run, n_run;
    logic           r_done, n_done;
    logic [DW-1:0]  r_gcd, n_gcd;
    logic [DW-1:0]  w_or;
    logic           w_a_ge_b;
    logic [DW-1:0]  w_diff;

    assign w_or     = r_a | r_b;
    assign w_a_ge_b = (r_a >= r_b);
    assign w_diff   = w_a_ge_b ? (r_a - r_b) : (r_b - r_a);

    always_comb begin
        n_a    = r_a;
        n_b    = r_b;
        n_k    = r_k;
        n_run  = r_run;
        n_done = 1'b0;
        n_gcd  = r_gcd;
        if (i_req.start) begin
            n_a   = i_a;
            n_b   = i_b;
            n_k   = '0;
            n_run = 1'b1;
        end else if (r_run) begin
            if (r_a == '0 || r_b == '0) begin
                // one operand gone: restore the common power of two
                n_gcd  = DW'(w_or << r_k);
                n_run  = 1'b0;
                n_done = 1'b1;
            end else if (!r_a[0] && !r_b[0]) begin
                n_a = r_a >> 1;
                n_b = r_b >> 1;
                n_k = r_k + K_W'(1);
            end else if (!r_a[0]) begin
                n_a = r_a >> 1;
            end else if (!r_b[0]) begin
                n_b = r_b >> 1;
            end else if (w_a_ge_b) begin
                n_a = w_diff >> 1;
            end else begin
                n_b = w_diff >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_run  <= n_run;
            r_done <= n_done;
        end
        r_a   <= n_a;
        r_b   <= n_b;
        r_k   <= n_k;
        r_gcd <= n_gcd;
    end

    assign o_rsp.busy = r_run;
    assign o_rsp.done = r_done;
    assign o_gcd      = r_gcd;

endmodule

// ----- rtl/running_gcd_resolution.sv -----
// Top level of the running GCD resolution block: sequencer, set state, output register.
`timescale 1ns / 1ps

// Usage:
//   Input channel (i_valid / o_ready) carries one signed value per transaction
//   with a missing flag and a last marker. Output channel (o_valid / i_ready)
//   carries one resolution per set, produced by the transaction marked last.
//   A value that enters the divisor runs a binary GCD against the running
//   divisor in the shift/subtract unit, one step per cycle. Such a
//   transaction is accepted, launched into the unit and its result handed
//   back to the divisor, and the input is held until then. Missing items,
//   the most negative pattern and items arriving once the divisor is 1 skip
//   the unit.
//   o_ready is high only while the sequencer is idle, so one transaction is
//   in work at a time. A last transaction then passes the emit state, which
//   loads the output register; the result appears on o_valid the cycle after.
//   If the receiver stalls, the result holds in the output register and the
//   block keeps taking transactions of the next set; it waits only when a
//   second result is due while the first is still untaken.
//   Reset (synchronous, active low) clears the divisor, the item count, the
//   sequencer and o_valid.
module running_gcd_resolution #(
    parameter int unsigned VALUE_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [VALUE_WIDTH-1:0] i_value,
    input  logic                          i_missing,
    input  logic                          i_last,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [rgcd_pkg::RES_W-1:0]    o_resolution
);
    import rgcd_pkg::*;

    localparam int unsigned DW = VALUE_WIDTH - 1;

    t_state                  r_state, n_state;
    logic [DW-1:0]           r_div, n_div;
    logic [1:0]              r_seen, n_seen;
    logic                    r_last, n_last;
    logic [DW-1:0]           r_mag, n_mag;
    logic                    r_out_valid, n_out_valid;
    logic [RES_W-1:0]        r_res, n_res;
    // Start pending flag: set when an item is taken into the GCD unit, dropped at launch.
    logic                    r_start_pend, n_start_pend;

    logic                    w_accept;
    logic                    w_min_neg;
    logic [VALUE_WIDTH-1:0]  w_neg;
    logic [DW-1:0]           w_abs;
    logic                    w_enter;
    logic                    w_out_free;
    t_gcd_req                w_req;
    t_gcd_rsp                w_rsp;
    logic [DW-1:0]           w_gcd;

    assign w_accept   = i_valid && o_ready;
    assign w_min_neg  = (i_value == {1'b1, {DW{1'b0}}});
    assign w_neg      = ~i_value + VALUE_WIDTH'(1);
    assign w_abs      = i_value[VALUE_WIDTH-1] ? w_neg[DW-1:0] : i_value[DW-1:0];
    // Fold the value in only when it has a magnitude and the divisor can still shrink.
    assign w_enter    = !i_missing && !w_min_neg && (r_div != DW'(1));
    assign w_out_free = !r_out_valid || i_ready;

    rgcd_core #(
        .DW(DW)
    ) u_core (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_req),
        .i_a    (r_mag),
        .i_b    (r_div),
        .o_rsp  (w_rsp),
        .o_gcd  (w_gcd)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (w_enter) begin
                        n_state = ST_CALC;
                    end else if (i_last) begin
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_CALC: begin
                if (w_rsp.done) begin
                    n_state = r_last ? ST_EMIT : ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs and datapath updates.
    always_comb begin
        o_ready     = 1'b0;
        w_req.start = 1'b0;
        n_div       = r_div;
        n_seen      = r_seen;
        n_last      = r_last;
        n_mag       = r_mag;
        n_out_valid = r_out_valid;
        n_res       = r_res;
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (w_accept) begin
                    // count the item, saturating at two
                    if (r_seen != 2'd2) begin
                        n_seen = r_seen + 2'd1;
                    end
                    n_last = i_last;
                    n_mag  = w_abs;
                end
            end
            ST_CALC: begin
                // launch on entry; the unit holds its operands from here on
                w_req.start = !w_rsp.busy && !w_rsp.done && (r_state == ST_CALC)
                              && r_start_pend;
                if (w_rsp.done) begin
                    n_div = w_gcd;
                end
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    if (r_seen == 2'd1 || r_div[DW-1:1] == '0) begin
                        n_res = RES_W'(1);
                    end else begin
                        n_res = RES_W'(r_div);
                    end
                    n_div  = '0;
                    n_seen = 2'd0;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        n_start_pend = r_start_pend;
        if (r_state == ST_IDLE && w_accept && w_enter) begin
            n_start_pend = 1'b1;
        end else if (w_req.start) begin
            n_start_pend = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_div        <= '0;
            r_seen       <= 2'd0;
            r_out_valid  <= 1'b0;
            r_start_pend <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_div        <= n_div;
            r_seen       <= n_seen;
            r_out_valid  <= n_out_valid;
            r_start_pend <= n_start_pend;
        end
        r_last <= n_last;
        r_mag  <= n_mag;
        r_res  <= n_res;
    end

    assign o_valid      = r_out_valid;
    assign o_resolution = r_res;

endmodule

// ----- tb/tb_running_gcd_resolution.sv -----
// Self-checking testbench for the running GCD resolution block.
`timescale 1ns / 1ps

// Drives sets of signed values through the input channel, predicts each set's
// resolution from a private GCD fold, and checks every result transaction in
// order. Directed sets come first. A long receiver hold-off and two drain pauses
// follow, then a long stream of random sets built around a chosen common
// divisor. Both channels idle at random, except during one calm stretch.
module tb_running_gcd_resolution;
    import rgcd_pkg::*;

    localparam int unsigned VW          = 32;
    localparam int          ITEM_TARGET = 1100;
    // Worst binary GCD run plus the output load, with some margin.
    localparam int          SETTLE_CYC  = 2 * (VW - 1) + 16;
    localparam int          CYCLE_LIMIT = 800000;
    localparam int          IDLE_PCT    = 8;
    localparam int          LONG_HOLD   = 1500;
    localparam logic signed [VW-1:0] MOST_NEG = {1'b1, {(VW-1){1'b0}}};
    localparam logic signed [VW-1:0] MOST_POS = {1'b0, {(VW-1){1'b1}}};

    // DUT inputs start at known values.
    logic                   i_clk     = 1'b0;
    logic                   i_rst_n   = 1'b0;
    logic                   i_valid   = 1'b0;
    logic signed [VW-1:0]   i_value   = '0;
    logic                   i_missing = 1'b0;
    logic                   i_last    = 1'b0;
    logic                   i_ready   = 1'b0;
    logic                   o_ready;
    logic                   o_valid;
    logic [RES_W-1:0]       o_resolution;

    // Predictor state: running divisor and item count of the open set.
    logic [VW-2:0]          divisor_acc = '0;
    logic [1:0]             set_len     = '0;
    logic [RES_W-1:0]       pending_res[$];

    int                     n_items     = 0;
    int                     n_checked   = 0;
    int                     n_errors    = 0;
    int                     cycle_count = 0;
    bit                     calm        = 1'b0;   // no idling on either side
    int                     rx_hold_req = 0;      // long hold-off request
    int                     rx_hold_left = 0;
    logic [RES_W-1:0]       want_res;

    running_gcd_resolution #(
        .VALUE_WIDTH (VW)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_value      (i_value),
        .i_missing    (i_missing),
        .i_last       (i_last),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_resolution (o_resolution)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Plain Euclid over the divisor width.
    function automatic logic [VW-2:0] gcd_of(input logic [VW-2:0] a, input logic [VW-2:0] b);
        logic [VW-2:0] r;
        while (b != 0) begin
            r = a % b;
            a = b;
            b = r;
        end
        return a;
    endfunction

    // Fold one accepted transaction into the predicted set state; on the last
    // one, queue the resolution and clear the state.
    task automatic predict_resolution(input logic signed [VW-1:0] v, input logic miss,
                                      input logic lst);
        logic [VW-1:0] neg;
        logic [VW-2:0] mag;
        if (set_len < 2) set_len++;
        // The most negative pattern has no magnitude: skip it like a missing item.
        if (!miss && v != MOST_NEG && divisor_acc != 1) begin
            neg = -v;
            mag = v[VW-1] ? neg[VW-2:0] : v[VW-2:0];
            divisor_acc = gcd_of(mag, divisor_acc);
        end
        if (lst) begin
            if (set_len == 1 || divisor_acc < 2)
                pending_res.push_back(RES_W'(1));
            else
                pending_res.push_back(RES_W'(divisor_acc));
            divisor_acc = '0;
            set_len     = '0;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [RES_W-1:0] want,
                                   input logic [RES_W-1:0] got);
        $display("MISMATCH cycle %0d: %s: expected %0d, got %0d", cycle_count, what, want, got);
        n_errors++;
    endtask

    // Offer one transaction and hold it until accepted. Called at a rising edge.
    task automatic send_item(input logic signed [VW-1:0] v, input logic miss, input logic lst);
        int gap;
        if (!calm && $urandom_range(99) < IDLE_PCT) begin
            // Mostly short gaps; now and then one long enough to find the block idle.
            gap = ($urandom_range(3) == 0) ? $urandom_range(1, 80) : $urandom_range(1, 3);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_value   <= v;
        i_missing <= miss;
        i_last    <= lst;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predict_resolution(v, miss, lst);
        n_items++;
    endtask

    // Drop valid, wait for every queued resolution, then let the block settle.
    task automatic wait_for_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_res.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    function automatic longint unsigned pick_divisor();
        case ($urandom_range(4))
            0:       return $urandom_range(2, 20);
            1:       return 64'd1 << $urandom_range(1, 30);
            2:       return $urandom_range(2, 32'h7FFF_FFFF);
            3:       return longint'($urandom_range(2, 12)) * $urandom_range(2, 12)
                            * $urandom_range(1, 30);
            default: return $urandom_range(1, 1000);
        endcase
    endfunction

    // Mostly multiples of the set divisor with a random sign, plus noise.
    function automatic logic signed [VW-1:0] pick_member(input longint unsigned g);
        longint unsigned k;
        logic signed [VW-1:0] v;
        int sel;
        sel = $urandom_range(99);
        if (sel < 70) begin
            k = $urandom_range(0, 32'(64'h7FFF_FFFF / g));
            v = VW'(k * g);
            if ($urandom_range(1)) v = -v;
        end else if (sel < 76) begin
            v = MOST_NEG;
        end else if (sel < 82) begin
            v = '0;
        end else if (sel < 94) begin
            v = $urandom;
        end else begin
            case ($urandom_range(3))
                0:       v = MOST_POS;
                1:       v = -MOST_POS;
                2:       v = 1;
                default: v = -1;
            endcase
        end
        return v;
    endfunction

    task automatic send_random_set(input int size);
        longint unsigned g;
        g = pick_divisor();
        for (int i = 0; i < size; i++) begin
            if ($urandom_range(9) == 0)
                send_item($urandom, 1'b1, i == size - 1);   // missing, garbage value
            else
                send_item(pick_member(g), 1'b0, i == size - 1);
        end
    endtask

    task automatic test_field_extremes();
        send_item(12, 1'b0, 1'b1);                  // one-item set
        send_item(MOST_POS, 1'b0, 1'b1);            // one-item set at the top
        send_item(MOST_POS, 1'b0, 1'b0);
        send_item(-MOST_POS, 1'b0, 1'b1);           // full-width divisor
        send_item(32'sd1073741824, 1'b0, 1'b0);
        send_item(-32'sd536870912, 1'b0, 1'b1);
    endtask

    task automatic test_special_cases();
        // Most negative pattern counts but does not enter the divisor.
        send_item(MOST_NEG, 1'b0, 1'b0);
        send_item(6, 1'b0, 1'b1);
        send_item(MOST_NEG, 1'b0, 1'b1);
        // Every item missing leaves the divisor at zero.
        send_item(5, 1'b1, 1'b0);
        send_item(-1, 1'b1, 1'b1);
        // Zeros leave the divisor alone.
        send_item(0, 1'b0, 1'b0);
        send_item(0, 1'b0, 1'b0);
        send_item(0, 1'b0, 1'b1);
        send_item(0, 1'b0, 1'b0);
        send_item(10, 1'b0, 1'b0);
        send_item(0, 1'b0, 1'b0);
        send_item(-15, 1'b0, 1'b1);
        // Divisor reaches one and sticks there.
        send_item(6, 1'b0, 1'b0);
        send_item(35, 1'b0, 1'b0);
        send_item(14, 1'b0, 1'b1);
        // A missing item's value is ignored.
        send_item(8, 1'b0, 1'b0);
        send_item(3, 1'b1, 1'b0);
        send_item(12, 1'b0, 1'b1);
    endtask

    // Hold the receiver off while short sets keep coming, so the output
    // register fills and the block stalls its input.
    task automatic test_backpressure();
        int sent;
        int base;
        wait_for_results();
        rx_hold_req = LONG_HOLD;
        base = n_items;
        sent = 0;
        while (sent < 40) begin
            send_random_set($urandom_range(1, 3));
            sent = n_items - base;
        end
    endtask

    // Pause the sender until everything has drained, twice.
    task automatic test_drain_pause();
        repeat (2) begin
            repeat (3) send_random_set($urandom_range(1, 4));
            wait_for_results();
        end
    endtask

    task automatic test_random_sets();
        while (n_items < ITEM_TARGET) begin
            calm = (n_items >= 500 && n_items < 700);
            send_random_set(($urandom_range(9) == 0) ? $urandom_range(6, 24)
                                                     : $urandom_range(1, 5));
        end
        calm = 1'b0;
    endtask

    // Receiver: random idling, or a long hold-off counted here.
    always @(posedge i_clk) begin
        if (rx_hold_req > 0) begin
            rx_hold_left = rx_hold_req;
            rx_hold_req  = 0;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Compare each result transaction against the oldest predicted resolution.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_res.size() == 0) begin
                report_mismatch("resolution with no set pending", '0, o_resolution);
            end else begin
                want_res = pending_res.pop_front();
                if (o_resolution !== want_res)
                    report_mismatch("resolution", want_res, o_resolution);
                n_checked++;
            end
        end
    end

    // Watchdog: end the run if it hangs.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("watchdog expired after %0d cycles, %0d resolutions outstanding",
                 cycle_count, pending_res.size());
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        // Hold reset, then release it once.
        i_rst_n <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_field_extremes();
        test_special_cases();
        test_backpressure();
        test_drain_pause();
        test_random_sets();
        wait_for_results();

        $display("Covered %0d transactions: field extremes, special cases, receiver hold-off,",
                 n_items);
        $display("drain pauses and random sets; %0d resolutions checked, %0d mismatches.",
                 n_checked, n_errors);
        if (n_errors == 0 && pending_res.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
